@@ rtl/wfgdd_pkg.sv @@
`timescale 1ns / 1ps

package wfgdd_pkg;

	// Default number of graph nodes, and the fixed width of a node index field.
	localparam int NODES_DEF  = 16;
	localparam int NODE_IDX_W = 4;
	localparam int ACTION_W   = 2;

	// Update actions carried in the action field of an input beat.
	typedef enum logic [ACTION_W-1:0] {
		ACT_ADD_NODE = 2'd0,
		ACT_ADD_EDGE = 2'd1,
		ACT_DEL_EDGE = 2'd2,
		ACT_NONE     = 2'd3
	} action_t;

endpackage

@@ rtl/wfgdd_in_if.sv @@
`timescale 1ns / 1ps

interface wfgdd_in_if;
	import wfgdd_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [ACTION_W-1:0]   action;
	logic [NODE_IDX_W-1:0] from_node;
	logic [NODE_IDX_W-1:0] to_node;

	modport source (output valid, output action, output from_node, output to_node,
		input ready);
	modport sink (input valid, input action, input from_node, input to_node,
		output ready);
endinterface

@@ rtl/wfgdd_out_if.sv @@
`timescale 1ns / 1ps

interface wfgdd_out_if;
	logic valid;
	logic ready;
	logic status;
	logic deadlock;

	modport source (output valid, output status, output deadlock, input ready);
	modport sink (input valid, input status, input deadlock, output ready);
endinterface

@@ rtl/wait_for_graph_deadlock_detector.sv @@
`timescale 1ns / 1ps

// Channel | Direction | Beat contents
// --------+-----------+------------------------------------------------
// req     | in        | action, from_node, to_node (one graph update)
// rsp     | out       | status, deadlock (one result per update)
//
// An update is applied in the cycle its beat is accepted; the cycle check then
// peels sink nodes, one pass of all adjacency rows per cycle, for at most NODES
// passes, and the done state loads the result register once that register is free.
// The peel loop sets the rate; req is not ready while a check is running.
// Reset clears the node set, the adjacency matrix and all control state at once.
// A stalled rsp holds its beat; a finished check waits until the register frees.

module wait_for_graph_deadlock_detector #(
	parameter int NODES = wfgdd_pkg::NODES_DEF
) (
	input logic         clk,
	input logic         arst_n,
	wfgdd_in_if.sink    req,
	wfgdd_out_if.source rsp
);
	import wfgdd_pkg::*;

	localparam int PASS_W = (NODES > 1) ? $clog2(NODES) : 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_PEEL = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                  state_q;
	logic [NODES-1:0]        present_q;
	logic [NODES-1:0]        rows_q [NODES];
	logic [NODES-1:0]        alive_q;
	logic [PASS_W-1:0]       pass_q;
	logic                    status_q;
	logic                    out_valid_q;
	logic                    out_status_q;
	logic                    out_deadlock_q;

	logic                    accept;
	logic                    slot_free;
	logic [NODES-1:0]        from_bit;
	logic [NODES-1:0]        to_bit;
	logic                    from_here;
	logic                    to_here;
	logic [NODES-1:0]        present_nxt;
	logic [NODES-1:0]        rows_nxt [NODES];
	logic                    status_nxt;
	logic [NODES-1:0]        keep;
	logic                    last_pass;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || rsp.ready;

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_status_q;
	assign rsp.deadlock = out_deadlock_q;

	// Decode the node indices; an index beyond the node count selects nothing.
	always_comb begin
		for (int i = 0; i < NODES; i++) begin
			from_bit[i] = (32'(req.from_node) == i);
			to_bit[i]   = (32'(req.to_node) == i);
		end
		from_here = |(present_q & from_bit);
		to_here   = |(present_q & to_bit);
	end

	// Next node set and adjacency rows for the update on the input beat.
	always_comb begin
		present_nxt = present_q;
		status_nxt  = 1'b0;
		for (int i = 0; i < NODES; i++) begin
			rows_nxt[i] = rows_q[i];
		end
		case (action_t'(req.action))
			ACT_ADD_NODE: begin
				if (from_bit == '0) begin
					status_nxt = 1'b1;
				end else begin
					present_nxt = present_q | from_bit;
				end
			end
			ACT_ADD_EDGE: begin
				if (from_here && to_here) begin
					for (int i = 0; i < NODES; i++) begin
						if (from_bit[i]) begin
							rows_nxt[i] = rows_q[i] | to_bit;
						end
					end
				end else begin
					status_nxt = 1'b1;
				end
			end
			ACT_DEL_EDGE: begin
				if (from_here) begin
					for (int i = 0; i < NODES; i++) begin
						if (from_bit[i]) begin
							rows_nxt[i] = rows_q[i] & ~to_bit;
						end
					end
				end else begin
					status_nxt = 1'b1;
				end
			end
			default: begin
				status_nxt = 1'b0;
			end
		endcase
	end

	// One peel pass: a node survives while it still has an edge into the live set.
	always_comb begin
		for (int i = 0; i < NODES; i++) begin
			keep[i] = alive_q[i] && (|(rows_q[i] & alive_q));
		end
		last_pass = (keep == alive_q) || (pass_q == PASS_W'(NODES - 1));
	end

	// Graph state is written only when an update beat is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			for (int i = 0; i < NODES; i++) begin
				rows_q[i] <= '0;
			end
		end else if (accept) begin
			present_q <= present_nxt;
			for (int i = 0; i < NODES; i++) begin
				rows_q[i] <= rows_nxt[i];
			end
		end
	end

	// Sequencer for the cycle check and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			alive_q     <= '0;
			pass_q      <= '0;
			status_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A taken beat empties the register unless a new one lands at once.
			if (out_valid_q && rsp.ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						alive_q  <= present_nxt;
						pass_q   <= '0;
						status_q <= status_nxt;
						state_q  <= ST_PEEL;
					end
				end
				ST_PEEL: begin
					alive_q <= keep;
					pass_q  <= pass_q + PASS_W'(1);
					if (last_pass) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload, loaded as the check hands over its beat.
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && slot_free) begin
			out_status_q   <= status_q;
			out_deadlock_q <= |alive_q;
		end
	end

`ifndef SYNTHESIS
	// An accepted update always starts a cycle check.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_PEEL))
		else $error("cycle check did not start after an update");

	// The pass counter never runs past the last pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PEEL) |-> (32'(pass_q) <= NODES - 1))
		else $error("peel pass counter overran");

	// The live set is always drawn from the nodes that exist.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PEEL) |-> ((alive_q & ~present_q) == '0))
		else $error("live set holds an absent node");

	// Peeling only ever removes nodes from the live set.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PEEL) |=> ((alive_q & ~$past(alive_q)) == '0))
		else $error("peel pass added a node to the live set");

	// A result is only offered after a check has finished.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result offered without a finished check");
`endif

endmodule
